// File: hdl/fqdp_pkg.sv
package fqdp_pkg;

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_PURGE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2,
        STS_ZDIV  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MARK,
        ST_COUNT,
        ST_PACK,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ENQ,
        CELL_DEQ,
        CELL_INIT,
        CELL_STEP,
        CELL_MARK,
        CELL_ROT,
        CELL_PACK
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     odd_phase;
    } t_cell_ctl;

endpackage

// File: hdl/fqdp_cell.sv
module fqdp_cell #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                  i_clk,
    input  fqdp_pkg::t_cell_ctl   i_ctl,
    input  logic [DATA_WIDTH-1:0] i_dmag,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic                  i_sel,
    input  logic                  i_inrange,
    input  logic                  i_odd_cell,
    input  logic                  i_has_left,
    input  logic                  i_has_right,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic                  i_right_live,
    input  logic                  i_left_live,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_live
);
    import fqdp_pkg::*;

    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic                  r_live, n_live;
    logic [DATA_WIDTH-1:0] r_shf, n_shf;
    logic [DATA_WIDTH:0]   r_rem, n_rem;
    logic [DATA_WIDTH-1:0] mag;
    logic [DATA_WIDTH:0]   trial;
    logic                  pair_r, pair_l;

    assign mag    = r_data[DATA_WIDTH-1] ? (~r_data + 1'b1) : r_data;
    // one restoring-division step: bring in the next dividend bit
    assign trial  = {r_rem[DATA_WIDTH-1:0], r_shf[DATA_WIDTH-1]};
    assign pair_r = i_has_right && (i_odd_cell == i_ctl.odd_phase);
    assign pair_l = i_has_left && (i_odd_cell != i_ctl.odd_phase);

    always_comb begin
        n_data = r_data;
        n_live = r_live;
        n_shf  = r_shf;
        n_rem  = r_rem;
        case (i_ctl.op)
            CELL_ENQ: begin
                if (i_sel) n_data = i_value;
            end
            CELL_DEQ: n_data = i_right_data;
            CELL_INIT: begin
                n_live = i_inrange;
                n_shf  = mag;
                n_rem  = '0;
            end
            CELL_STEP: begin
                n_shf = {r_shf[DATA_WIDTH-2:0], 1'b0};
                n_rem = (trial >= {1'b0, i_dmag}) ? trial - {1'b0, i_dmag} : trial;
            end
            CELL_MARK: n_live = r_live && (r_rem != '0);
            CELL_ROT: begin
                n_data = i_right_data;
                n_live = i_right_live;
            end
            CELL_PACK: begin
                // odd-even exchange: a live entry moves down past a dead one
                if (pair_r && !r_live && i_right_live) begin
                    n_data = i_right_data;
                    n_live = 1'b1;
                end else if (pair_l && !i_left_live && r_live) begin
                    n_live = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_live <= n_live;
        r_shf  <= n_shf;
        r_rem  <= n_rem;
    end

    assign o_data = r_data;
    assign o_live = r_live;

endmodule

// File: hdl/fifo_queue_with_divisor_purge.sv
// Bounded FIFO of signed words with a purge-by-divisor command.
// Input channel: i_valid / o_stall with i_command, i_value, i_divisor.
// Output channel: o_valid / i_stall with o_data_out, o_status, o_occupancy,
// o_removed_count; exactly one result item per accepted item.
// Storage is a row of DEPTH cells; entry 0 is the oldest.
// Enqueue, dequeue, error cases and unknown commands: the result is
// registered at the accept edge and shows the next cycle; one item per
// cycle while no stalled result blocks the output register. Purge: each
// cell runs a bit-serial remainder of its word by the divisor magnitude,
// then a rotation pass counts removed entries and an odd-even exchange
// pass packs survivors. The result is registered once the pack pass ends
// and the output register is free; no item is accepted meanwhile.
// A result that waits under i_stall holds; a new item is still accepted if
// the output register is free or is being taken in the same cycle.
// Reset (i_rst_n low, synchronous) empties the queue and drops any result.
module fifo_queue_with_divisor_purge #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_command,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic signed [DATA_WIDTH-1:0] i_divisor,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_data_out,
    output logic [1:0]                   o_status,
    output logic [$clog2(DEPTH+1)-1:0]   o_occupancy,
    output logic [$clog2(DEPTH+1)-1:0]   o_removed_count
);
    import fqdp_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int MAXN = (DEPTH > DATA_WIDTH) ? DEPTH : DATA_WIDTH;
    localparam int SW   = $clog2(MAXN + 1);

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_removed, n_removed;
    logic [SW-1:0]        r_step, n_step;
    logic                 r_odd, n_odd;
    logic [DATA_WIDTH-1:0] r_dmag, n_dmag;
    logic                 r_ovalid, n_ovalid;
    logic [DATA_WIDTH-1:0] r_odata, n_odata;
    t_status              r_ostatus, n_ostatus;
    logic [CW-1:0]        r_oocc, n_oocc;
    logic [CW-1:0]        r_orem, n_orem;

    t_cell_ctl            ctl;
    logic                 accept, out_free;
    logic [DATA_WIDTH-1:0] dmag_in;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic                 cell_live [DEPTH];

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE) || !out_free;
    assign accept   = i_valid && !o_stall;
    assign dmag_in  = i_divisor[DATA_WIDTH-1] ? (~i_divisor + 1'b1) : i_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_removed <= n_removed;
        r_step    <= n_step;
        r_odd     <= n_odd;
        r_dmag    <= n_dmag;
        r_odata   <= n_odata;
        r_ostatus <= n_ostatus;
        r_oocc    <= n_oocc;
        r_orem    <= n_orem;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_removed     = r_removed;
        n_step        = r_step;
        n_odd         = r_odd;
        n_dmag        = r_dmag;
        n_ovalid      = r_ovalid && i_stall;
        n_odata       = r_odata;
        n_ostatus     = r_ostatus;
        n_oocc        = r_oocc;
        n_orem        = r_orem;
        ctl.op        = CELL_HOLD;
        ctl.odd_phase = r_odd;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_ovalid  = 1'b1;
                    n_odata   = '0;
                    n_ostatus = STS_OK;
                    n_orem    = '0;
                    case (i_command)
                        CMD_ENQ: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_ostatus = STS_FULL;
                            end else begin
                                ctl.op  = CELL_ENQ;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_DEQ: begin
                            if (r_count == '0) begin
                                n_ostatus = STS_EMPTY;
                            end else begin
                                ctl.op  = CELL_DEQ;
                                n_odata = cell_data[0];
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_PURGE: begin
                            if (i_divisor == '0) begin
                                n_ostatus = STS_ZDIV;
                            end else begin
                                ctl.op   = CELL_INIT;
                                n_ovalid = 1'b0;
                                n_dmag   = dmag_in;
                                n_step   = '0;
                                n_state  = ST_DIV;
                            end
                        end
                        default: ;
                    endcase
                    n_oocc = n_count;
                end
            end
            ST_DIV: begin
                ctl.op = CELL_STEP;
                n_step = r_step + 1'b1;
                if (r_step == SW'(DATA_WIDTH - 1)) n_state = ST_MARK;
            end
            ST_MARK: begin
                ctl.op    = CELL_MARK;
                n_step    = '0;
                n_removed = '0;
                n_state   = ST_COUNT;
            end
            ST_COUNT: begin
                // cell 0 holds original entry r_step during this pass
                ctl.op = CELL_ROT;
                if (r_step < SW'(r_count) && !cell_live[0]) n_removed = r_removed + 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == SW'(DEPTH - 1)) begin
                    n_step  = '0;
                    n_odd   = 1'b0;
                    n_state = ST_PACK;
                end
            end
            ST_PACK: begin
                ctl.op = CELL_PACK;
                n_odd  = !r_odd;
                n_step = r_step + 1'b1;
                if (r_step == SW'(DEPTH - 1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_odata   = '0;
                    n_ostatus = STS_OK;
                    n_count   = r_count - r_removed;
                    n_oocc    = r_count - r_removed;
                    n_orem    = r_removed;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        fqdp_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_dmag      (r_dmag),
            .i_value     (i_value),
            .i_sel       (r_count == CW'(g)),
            .i_inrange   (CW'(g) < r_count),
            .i_odd_cell  (1'(g % 2)),
            .i_has_left  (g > 0),
            .i_has_right (g < DEPTH - 1),
            .i_right_data(cell_data[(g + 1) % DEPTH]),
            .i_right_live(cell_live[(g + 1) % DEPTH]),
            .i_left_live (cell_live[(g + DEPTH - 1) % DEPTH]),
            .o_data      (cell_data[g]),
            .o_live      (cell_live[g])
        );
    end

    assign o_valid         = r_ovalid;
    assign o_data_out      = r_odata;
    assign o_status        = r_ostatus;
    assign o_occupancy     = r_oocc;
    assign o_removed_count = r_orem;

endmodule

// File: hdl/fqdp_chk.sv
module fqdp_chk #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [DATA_WIDTH-1:0]      o_data_out,
    input logic [1:0]                 o_status,
    input logic [$clog2(DEPTH+1)-1:0] o_occupancy,
    input logic [$clog2(DEPTH+1)-1:0] o_removed_count
);
    import fqdp_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_occupancy <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STS_FULL) |-> o_occupancy == CW'(DEPTH))
        else $error("full reported on a queue with room");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STS_EMPTY) |-> (o_occupancy == '0 && o_data_out == '0))
        else $error("empty item carries data or occupancy");

    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_removed_count != '0) |-> o_status == STS_OK)
        else $error("removed entries with an error status");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data_out) && $stable(o_occupancy)))
        else $error("stalled item changed");

endmodule

bind fifo_queue_with_divisor_purge fqdp_chk #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
) u_fqdp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_data_out     (o_data_out),
    .o_status       (o_status),
    .o_occupancy    (o_occupancy),
    .o_removed_count(o_removed_count)
);
